/* hdl/rsh_pkg.sv */
// Shared types and constants for the rsh session recognizer.
// Request and result payloads, the classified queue entry and verdict codes.
// No dependencies.
`default_nettype none

package rsh_pkg;

  localparam int MAX_PORT_LEN_DEF = 6;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [1:0] V_INPROC    = 2'd0;
  localparam logic [1:0] V_FOUND     = 2'd1;
  localparam logic [1:0] V_NOTCOMPAT = 2'd2;
  localparam logic [1:0] V_NOMATCH   = 2'd3;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  localparam logic [16:0] PORT_MAX = 17'd65535;
  localparam logic [16:0] PORT_SAT = 17'd65536;

  typedef struct packed {
    logic       kind;
    logic       from_responder;
    logic       empty_packet;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       side_channel_ok;
  } rsh_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        open_side_channel;
    logic [15:0] side_port;
    logic        clear_continue;
    logic        clear_stderr_mark;
  } rsh_result_t;

  typedef struct packed {
    logic       kind;
    logic       resp;
    logic       empty;
    logic       first;
    logic       last;
    logic       ok;
    logic [3:0] digit;
    logic       is_zero;
    logic       is_digit;
    logic       is_print;
    logic       is_name;
    logic       is_soh;
    logic       is_ctl;
  } cls_item_t;

endpackage

`default_nettype wire

/* hdl/rsh_front.sv */
// Front end: accepts requests and classifies the payload byte.
// Pushes classified entries into the queue; depends on rsh_pkg.
`default_nettype none

module rsh_front import rsh_pkg::*; (
  input  wire        item_valid,
  output logic       item_stall,
  input  rsh_item_t  item,
  input  wire        q_full,
  output logic       q_push,
  output cls_item_t  q_entry
);

  logic [7:0] b;

  assign b          = item.data_byte;
  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    q_entry          = '0;
    q_entry.kind     = item.kind;
    q_entry.resp     = item.from_responder;
    q_entry.empty    = item.empty_packet;
    q_entry.first    = item.first_byte;
    q_entry.last     = item.last_byte;
    q_entry.ok       = item.side_channel_ok;
    q_entry.digit    = b[3:0];
    q_entry.is_zero  = (b == 8'h00);
    q_entry.is_digit = (b >= 8'h30) && (b <= 8'h39);
    q_entry.is_print = (b >= 8'h20) && (b <= 8'h7E);
    q_entry.is_name  = (b >= 8'h21) && (b <= 8'h7E);
    q_entry.is_soh   = (b == BYTE_SOH);
    q_entry.is_ctl   = (b == BYTE_LF) || (b == BYTE_CR) || (b == BYTE_TAB);
  end

endmodule

`default_nettype wire

/* hdl/rsh_queue.sv */
// Short queue of classified requests between front end and back end.
// Register array with read and write pointers; depends on rsh_pkg.
`default_nettype none

module rsh_queue import rsh_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  cls_item_t  push_data,
  input  wire        pop,
  output cls_item_t  pop_data,
  output logic       full,
  output logic       empty
);

  cls_item_t          slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full     = (count == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/rsh_back.sv */
// Back end: main and stderr flow state machines and the result register.
// Pops one classified request per cycle when the result side can take it; depends on rsh_pkg.
`default_nettype none

module rsh_back import rsh_pkg::*; #(
  parameter int MAX_PORT_LEN = MAX_PORT_LEN_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          q_empty,
  input  cls_item_t    q_data,
  output logic         q_pop,
  output logic         result_valid,
  input  wire          result_stall,
  output rsh_result_t  result
);

  typedef enum logic [6:0] {
    MP_PORT    = 7'b0000001,
    MP_CONNECT = 7'b0000010,
    MP_USER    = 7'b0000100,
    MP_USER2   = 7'b0001000,
    MP_COMMAND = 7'b0010000,
    MP_REPLY   = 7'b0100000,
    MP_BAIL    = 7'b1000000
  } main_phase_t;

  typedef enum logic [5:0] {
    SD_NONE   = 6'b000001,
    SD_SYN    = 6'b000010,
    SD_SYNACK = 6'b000100,
    SD_WAIT   = 6'b001000,
    SD_DONE   = 6'b010000,
    SD_BAIL   = 6'b100000
  } side_phase_t;

  main_phase_t main_phase, main_phase_next;
  side_phase_t side_phase, side_phase_next;
  logic        main_subfield, main_subfield_next;
  logic [16:0] port_value, port_value_next;
  logic [2:0]  bytes_in_packet, bytes_in_packet_next;
  logic [1:0]  pending_verdict, pending_verdict_next;
  logic        packet_decided, packet_decided_next;
  logic        reply_text_ended, reply_text_ended_next;

  rsh_result_t res;
  logic        res_valid;
  logic        dec;
  logic [1:0]  dec_v;
  logic        side_bail;
  logic [16:0] pv_base;
  logic [19:0] pv_prod;
  logic [2:0]  pos;

  assign q_pop   = !q_empty && (!result_valid || !result_stall);
  assign pv_base = q_data.first ? '0 : port_value;
  assign pv_prod = {pv_base, 3'b000} + {2'b00, pv_base, 1'b0} + {16'd0, q_data.digit};
  assign pos     = q_data.first ? '0 : bytes_in_packet;

  always_comb begin
    main_phase_next       = main_phase;
    side_phase_next       = side_phase;
    main_subfield_next    = main_subfield;
    port_value_next       = port_value;
    bytes_in_packet_next  = bytes_in_packet;
    pending_verdict_next  = pending_verdict;
    packet_decided_next   = packet_decided;
    reply_text_ended_next = reply_text_ended;
    res       = '0;
    res_valid = 1'b0;
    dec       = 1'b0;
    dec_v     = V_INPROC;
    side_bail = 1'b0;

    if (q_data.kind) begin
      if (q_data.empty || q_data.last) begin
        res_valid = 1'b1;
        unique case (side_phase)
          SD_NONE: begin
            res.verdict = V_NOMATCH;
          end
          SD_SYN: begin
            side_phase_next = SD_SYNACK;
          end
          SD_SYNACK: begin
            if (main_phase == MP_CONNECT) begin
              main_phase_next = MP_USER;
              side_phase_next = SD_WAIT;
            end else begin
              side_bail = 1'b1;
            end
          end
          SD_WAIT: begin
            side_bail = !q_data.empty;
          end
          SD_DONE: begin
            res.verdict           = V_FOUND;
            res.clear_continue    = 1'b1;
            res.clear_stderr_mark = 1'b1;
          end
          default: begin
            side_bail = 1'b1;
          end
        endcase
        if (side_bail) begin
          main_phase_next       = MP_BAIL;
          side_phase_next       = SD_BAIL;
          res.verdict           = V_NOTCOMPAT;
          res.clear_stderr_mark = 1'b1;
        end
      end
    end else if (q_data.empty) begin
      res_valid = 1'b1;
      if (main_phase == MP_BAIL) begin
        if (side_phase != SD_NONE) begin
          side_phase_next = SD_BAIL;
        end
        res.verdict           = V_NOTCOMPAT;
        res.clear_stderr_mark = 1'b1;
      end
      main_subfield_next    = 1'b0;
      port_value_next       = '0;
      bytes_in_packet_next  = '0;
      pending_verdict_next  = V_INPROC;
      packet_decided_next   = 1'b0;
      reply_text_ended_next = 1'b0;
    end else begin
      if (q_data.first) begin
        main_subfield_next    = 1'b0;
        port_value_next       = '0;
        bytes_in_packet_next  = '0;
        pending_verdict_next  = V_INPROC;
        packet_decided_next   = 1'b0;
        reply_text_ended_next = 1'b0;
      end

      if (!packet_decided_next) begin
        unique case (main_phase) inside
          MP_PORT: begin
            if (q_data.resp) begin
              dec = 1'b1; dec_v = V_NOMATCH;
            end else if (pos >= 3'(MAX_PORT_LEN)) begin
              dec = 1'b1; dec_v = V_NOTCOMPAT;
            end else if (q_data.last) begin
              if (!q_data.is_zero || pv_base > PORT_MAX) begin
                dec = 1'b1; dec_v = V_NOTCOMPAT;
              end else if (pv_base != '0 && q_data.ok) begin
                side_phase_next       = SD_SYN;
                main_phase_next       = MP_CONNECT;
                res.verdict           = V_FOUND;
                res.open_side_channel = 1'b1;
                res.side_port         = pv_base[15:0];
              end else begin
                main_phase_next = MP_USER;
              end
            end else if (!q_data.is_digit) begin
              dec = 1'b1; dec_v = V_NOTCOMPAT;
            end else if (pv_prod > {3'b000, PORT_MAX}) begin
              port_value_next = PORT_SAT;
            end else begin
              port_value_next = pv_prod[16:0];
            end
          end
          MP_CONNECT: begin
            dec = 1'b1; dec_v = V_NOMATCH;
          end
          MP_USER, MP_USER2: begin
            if (q_data.resp) begin
              dec = 1'b1; dec_v = V_NOMATCH;
            end else if (q_data.is_zero) begin
              main_phase_next    = (main_phase == MP_USER) ? MP_USER2 : MP_COMMAND;
              main_subfield_next = 1'b0;
            end else if (!q_data.is_name || q_data.last) begin
              dec = 1'b1; dec_v = V_NOTCOMPAT;
            end
          end
          MP_COMMAND: begin
            if (q_data.resp) begin
              dec = 1'b1; dec_v = V_NOMATCH;
            end else if (q_data.is_zero) begin
              if (q_data.last) begin
                main_phase_next = MP_REPLY;
              end else if (!main_subfield_next) begin
                main_subfield_next = 1'b1;
              end else begin
                dec = 1'b1; dec_v = V_NOTCOMPAT;
              end
            end else if (!q_data.is_print || q_data.last) begin
              dec = 1'b1; dec_v = V_NOTCOMPAT;
            end
          end
          MP_REPLY: begin
            if (!q_data.resp) begin
              dec = 1'b1; dec_v = V_NOMATCH;
            end else if (pos == '0 && !q_data.last && !q_data.is_soh) begin
              dec = 1'b1; dec_v = V_NOMATCH;
            end else if (pos != '0 && !reply_text_ended_next && !q_data.is_zero
                         && !q_data.is_print && !q_data.is_ctl) begin
              dec = 1'b1; dec_v = V_NOMATCH;
            end else begin
              if (pos != '0 && !reply_text_ended_next && q_data.is_zero) begin
                reply_text_ended_next = 1'b1;
              end
              if (q_data.last) begin
                if (side_phase != SD_NONE && side_phase != SD_WAIT) begin
                  dec = 1'b1; dec_v = V_NOMATCH;
                end else begin
                  if (side_phase == SD_WAIT) begin
                    side_phase_next = SD_DONE;
                  end
                  res.verdict        = V_FOUND;
                  res.clear_continue = 1'b1;
                end
              end
            end
          end
          default: begin
            dec = 1'b1; dec_v = V_NOTCOMPAT;
          end
        endcase

        if (dec) begin
          pending_verdict_next = dec_v;
          packet_decided_next  = 1'b1;
          main_phase_next      = MP_BAIL;
          side_phase_next      = (side_phase == SD_NONE) ? SD_NONE : SD_BAIL;
        end
      end

      if (!q_data.last) begin
        if (bytes_in_packet_next != 3'd7) begin
          bytes_in_packet_next = bytes_in_packet_next + 1'b1;
        end
      end else begin
        res_valid = 1'b1;
        if (packet_decided_next) begin
          res                   = '0;
          res.verdict           = pending_verdict_next;
          res.clear_stderr_mark = 1'b1;
        end
        main_subfield_next    = 1'b0;
        port_value_next       = '0;
        bytes_in_packet_next  = '0;
        pending_verdict_next  = V_INPROC;
        packet_decided_next   = 1'b0;
        reply_text_ended_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase       <= MP_PORT;
      side_phase       <= SD_NONE;
      main_subfield    <= 1'b0;
      port_value       <= '0;
      bytes_in_packet  <= '0;
      pending_verdict  <= V_INPROC;
      packet_decided   <= 1'b0;
      reply_text_ended <= 1'b0;
    end else if (q_pop) begin
      main_phase       <= main_phase_next;
      side_phase       <= side_phase_next;
      main_subfield    <= main_subfield_next;
      port_value       <= port_value_next;
      bytes_in_packet  <= bytes_in_packet_next;
      pending_verdict  <= pending_verdict_next;
      packet_decided   <= packet_decided_next;
      reply_text_ended <= reply_text_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= q_pop && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

/* hdl/rsh_session_recognizer.sv */
// rsh session recognizer: takes one payload byte (or an empty-packet marker) of
// the main or stderr flow per request and gives one verdict per packet. It
// accepts a request every cycle while the queue is not full; a verdict is
// registered once its request has passed the queue, and bytes that end no
// packet give no result. The rate is set by the back-end state update, which
// retires one queued request per cycle while the result register is free or
// being taken. Top level; depends on rsh_pkg, rsh_front, rsh_queue and rsh_back.
`default_nettype none

module rsh_session_recognizer import rsh_pkg::*; #(
  parameter int MAX_PORT_LEN = MAX_PORT_LEN_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          item_valid,
  output logic         item_stall,
  input  rsh_item_t    item,
  output logic         result_valid,
  input  wire          result_stall,
  output rsh_result_t  result
);

  cls_item_t q_entry;
  cls_item_t q_data;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  rsh_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  rsh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rsh_back #(
    .MAX_PORT_LEN (MAX_PORT_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_open_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.open_side_channel |-> result.verdict == V_FOUND)
    else $error("side channel requested without identified verdict");

  a_port_only_open: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.open_side_channel |-> result.side_port == 16'd0)
    else $error("side port set without side channel request");

  a_clear_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.clear_continue |-> result.verdict == V_FOUND)
    else $error("clear continue without identified verdict");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

/* tb/rsh_session_checker.sv */
`timescale 1ns / 100ps
// Checker for rsh_session_recognizer. It watches the request and verdict channels,
// keeps its own copy of the session state, and compares every verdict field by field.
// Depends on rsh_pkg.
module rsh_session_checker import rsh_pkg::*; #(
  parameter int MAX_PORT_LEN = MAX_PORT_LEN_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         item_valid,
  input  wire         item_stall,
  input  rsh_item_t   item,
  input  wire         result_valid,
  input  wire         result_stall,
  input  rsh_result_t result,
  output int          fail_count,
  output int          pending,
  output int          n_requests,
  output int          n_found,
  output int          n_notcompat,
  output int          n_nomatch,
  output int          n_inproc,
  output int          n_opens
);

  typedef enum logic [2:0] {
    MS_PORT    = 3'd0,
    MS_CONNECT = 3'd1,
    MS_USER    = 3'd2,
    MS_USER2   = 3'd3,
    MS_COMMAND = 3'd4,
    MS_REPLY   = 3'd5,
    MS_BAIL    = 3'd7
  } main_stage_t;

  typedef enum logic [2:0] {
    SS_NONE   = 3'd0,
    SS_SYN    = 3'd1,
    SS_SYNACK = 3'd2,
    SS_WAIT   = 3'd3,
    SS_DONE   = 3'd4,
    SS_BAIL   = 3'd5
  } side_stage_t;

  localparam logic [7:0] NUL      = 8'h00;
  localparam logic [7:0] DIGIT_0  = 8'h30;
  localparam logic [7:0] DIGIT_9  = 8'h39;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] NAME_LO  = 8'h21;
  localparam logic [7:0] PRINT_HI = 8'h7E;
  localparam logic [2:0] POS_CAP  = 3'd7;

  main_stage_t main_stage;
  side_stage_t side_stage;
  logic        in_stdin;
  logic [16:0] port_acc;
  logic [2:0]  pkt_pos;
  logic [1:0]  held_verdict;
  logic        pkt_decided;
  logic        reply_ended;
  rsh_result_t verdict_out;
  rsh_result_t expected_verdicts[$];

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    fail_count++;
  endtask

  function automatic bit printable(input logic [7:0] b);
    return b >= PRINT_LO && b <= PRINT_HI;
  endfunction

  function automatic bit name_char(input logic [7:0] b);
    return b >= NAME_LO && b <= PRINT_HI;
  endfunction

  function automatic void restart_packet();
    in_stdin     = 1'b0;
    port_acc     = '0;
    pkt_pos      = '0;
    held_verdict = V_INPROC;
    pkt_decided  = 1'b0;
    reply_ended  = 1'b0;
  endfunction

  function automatic void abandon_all();
    main_stage = MS_BAIL;
    if (side_stage != SS_NONE) side_stage = SS_BAIL;
  endfunction

  function automatic void settle(input logic [1:0] v);
    held_verdict = v;
    pkt_decided  = 1'b1;
    abandon_all();
  endfunction

  function automatic void finish_reply();
    if (side_stage != SS_NONE) begin
      if (side_stage == SS_WAIT) begin
        side_stage = SS_DONE;
      end else begin
        settle(V_NOMATCH);
        return;
      end
    end
    verdict_out.verdict        = V_FOUND;
    verdict_out.clear_continue = 1'b1;
  endfunction

  function automatic void parse_main_byte(input logic [7:0] b, input logic last,
                                          input logic resp, input logic ok);
    int acc;
    case (main_stage) inside
      MS_PORT: begin
        if (resp) begin
          settle(V_NOMATCH);
        end else if (int'(pkt_pos) + 1 > MAX_PORT_LEN) begin
          settle(V_NOTCOMPAT);
        end else if (last) begin
          if (b != NUL || port_acc > PORT_MAX) begin
            settle(V_NOTCOMPAT);
          end else if (port_acc != '0 && ok) begin
            side_stage                    = SS_SYN;
            main_stage                    = MS_CONNECT;
            verdict_out.verdict           = V_FOUND;
            verdict_out.open_side_channel = 1'b1;
            verdict_out.side_port         = port_acc[15:0];
          end else begin
            main_stage = MS_USER;
          end
        end else if (b < DIGIT_0 || b > DIGIT_9) begin
          settle(V_NOTCOMPAT);
        end else begin
          acc = int'(port_acc) * 10 + int'(b - DIGIT_0);
          if (acc > int'(PORT_MAX)) acc = int'(PORT_SAT);
          port_acc = acc[16:0];
        end
      end
      MS_CONNECT: settle(V_NOMATCH);
      MS_USER, MS_USER2: begin
        if (resp) begin
          settle(V_NOMATCH);
        end else if (b == NUL) begin
          main_stage = (main_stage == MS_USER) ? MS_USER2 : MS_COMMAND;
          in_stdin   = 1'b0;
        end else if (!name_char(b) || last) begin
          settle(V_NOTCOMPAT);
        end
      end
      MS_COMMAND: begin
        if (resp) begin
          settle(V_NOMATCH);
        end else if (b == NUL) begin
          if (last) main_stage = MS_REPLY;
          else if (!in_stdin) in_stdin = 1'b1;
          else settle(V_NOTCOMPAT);
        end else if (!printable(b) || last) begin
          settle(V_NOTCOMPAT);
        end
      end
      MS_REPLY: begin
        if (!resp) begin
          settle(V_NOMATCH);
        end else if (pkt_pos == '0) begin
          if (last) finish_reply();
          else if (b != BYTE_SOH) settle(V_NOMATCH);
        end else begin
          if (!reply_ended) begin
            if (b == NUL) begin
              reply_ended = 1'b1;
            end else if (!printable(b) && b != BYTE_LF && b != BYTE_CR && b != BYTE_TAB) begin
              settle(V_NOMATCH);
              return;
            end
          end
          if (last) finish_reply();
        end
      end
      default: settle(V_NOTCOMPAT);
    endcase
  endfunction

  function automatic void side_flow_packet(input logic empty);
    case (side_stage)
      SS_NONE: begin
        verdict_out.verdict = V_NOMATCH;
        return;
      end
      SS_SYN: begin
        side_stage = SS_SYNACK;
        return;
      end
      SS_SYNACK: begin
        if (main_stage == MS_CONNECT) begin
          main_stage = MS_USER;
          side_stage = SS_WAIT;
          return;
        end
      end
      SS_WAIT: begin
        if (empty) return;
      end
      SS_DONE: begin
        verdict_out.verdict           = V_FOUND;
        verdict_out.clear_continue    = 1'b1;
        verdict_out.clear_stderr_mark = 1'b1;
        return;
      end
      default: ;
    endcase
    abandon_all();
    verdict_out.verdict           = V_NOTCOMPAT;
    verdict_out.clear_stderr_mark = 1'b1;
  endfunction

  function automatic void predict_request(input rsh_item_t req);
    verdict_out = '0;
    if (req.kind) begin
      if (!req.empty_packet && !req.last_byte) return;
      side_flow_packet(req.empty_packet);
      expected_verdicts.push_back(verdict_out);
      return;
    end
    if (req.empty_packet) begin
      if (main_stage > MS_REPLY) begin
        abandon_all();
        verdict_out.verdict           = V_NOTCOMPAT;
        verdict_out.clear_stderr_mark = 1'b1;
      end
      restart_packet();
      expected_verdicts.push_back(verdict_out);
      return;
    end
    if (req.first_byte) restart_packet();
    if (!pkt_decided) parse_main_byte(req.data_byte, req.last_byte, req.from_responder,
                                      req.side_channel_ok);
    if (!req.last_byte) begin
      if (pkt_pos < POS_CAP) pkt_pos++;
      return;
    end
    if (pkt_decided) begin
      verdict_out                   = '0;
      verdict_out.verdict           = held_verdict;
      verdict_out.clear_stderr_mark = 1'b1;
    end
    restart_packet();
    expected_verdicts.push_back(verdict_out);
  endfunction

  always @(posedge clk) begin
    rsh_result_t want;
    if (rst) begin
      main_stage = MS_PORT;
      side_stage = SS_NONE;
      restart_packet();
      expected_verdicts.delete();
      fail_count  = 0;
      n_requests  = 0;
      n_found     = 0;
      n_notcompat = 0;
      n_nomatch   = 0;
      n_inproc    = 0;
      n_opens     = 0;
    end else begin
      if (item_valid && !item_stall) begin
        n_requests++;
        predict_request(item);
      end
      if (result_valid && !result_stall) begin
        case (result.verdict)
          V_INPROC:    n_inproc++;
          V_FOUND:     n_found++;
          V_NOTCOMPAT: n_notcompat++;
          V_NOMATCH:   n_nomatch++;
          default: ;
        endcase
        if (result.open_side_channel === 1'b1) n_opens++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("verdict with no packet pending, packed result", 0, result);
        end else begin
          want = expected_verdicts.pop_front();
          if (result.verdict !== want.verdict)
            report_mismatch("verdict", want.verdict, result.verdict);
          if (result.open_side_channel !== want.open_side_channel)
            report_mismatch("open_side_channel", want.open_side_channel,
                            result.open_side_channel);
          if (result.side_port !== want.side_port)
            report_mismatch("side_port", want.side_port, result.side_port);
          if (result.clear_continue !== want.clear_continue)
            report_mismatch("clear_continue", want.clear_continue, result.clear_continue);
          if (result.clear_stderr_mark !== want.clear_stderr_mark)
            report_mismatch("clear_stderr_mark", want.clear_stderr_mark,
                            result.clear_stderr_mark);
        end
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

/* tb/tb_rsh_session_recognizer.sv */
`timescale 1ns / 100ps
// Testbench top for rsh_session_recognizer: clock, reset, request stimulus for one
// rsh session with random gaps and result hold-offs, and the final verdict.
// Depends on rsh_pkg, rsh_session_recognizer and rsh_session_checker.
module tb_rsh_session_recognizer;
  import rsh_pkg::*;

  localparam int         ITEM_TARGET  = 2000;
  localparam int         LONG_HOLD    = 300;
  localparam int         DRAIN_CYCLES = 20;
  localparam logic       KIND_MAIN    = 1'b0;
  localparam logic       KIND_SIDE    = 1'b1;
  localparam logic [7:0] NUL          = 8'h00;
  localparam logic [7:0] DIGIT_0      = 8'h30;
  localparam logic [7:0] DIGIT_9      = 8'h39;
  localparam logic [7:0] PRINT_LO     = 8'h20;
  localparam logic [7:0] NAME_LO      = 8'h21;
  localparam logic [7:0] PRINT_HI     = 8'h7E;

  typedef logic [7:0] byte_q_t[$];

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  rsh_item_t   item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  rsh_result_t result;

  int fail_count, pending, n_requests;
  int n_found, n_notcompat, n_nomatch, n_inproc, n_opens;
  int sent         = 0;
  int long_holds   = 0;
  int tx_mode_left = 0;
  bit tx_quiet     = 1'b0;
  byte_q_t pkt_bytes;

  rsh_session_recognizer #(.MAX_PORT_LEN(MAX_PORT_LEN_DEF)) uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  rsh_session_checker #(.MAX_PORT_LEN(MAX_PORT_LEN_DEF)) chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending),
    .n_requests   (n_requests),
    .n_found      (n_found),
    .n_notcompat  (n_notcompat),
    .n_nomatch    (n_nomatch),
    .n_inproc     (n_inproc),
    .n_opens      (n_opens)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rbyte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic rsh_item_t make_req(input logic kind, input logic resp,
                                         input logic empty, input logic [7:0] b,
                                         input logic first, input logic last,
                                         input logic ok);
    rsh_item_t req;
    req.kind            = kind;
    req.from_responder  = resp;
    req.empty_packet    = empty;
    req.data_byte       = b;
    req.first_byte      = first;
    req.last_byte       = last;
    req.side_channel_ok = ok;
    return req;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_text(input string txt);
    for (int i = 0; i < txt.len(); i++) pkt_bytes.push_back(txt[i]);
  endfunction

  function automatic logic [7:0] reply_char();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return BYTE_LF;
    if (r == 1) return BYTE_CR;
    if (r == 2) return BYTE_TAB;
    return 8'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  task automatic send_request(input rsh_item_t req);
    int gap;
    if (tx_mode_left == 0) begin
      tx_quiet     = ($urandom_range(0, 3) == 0);
      tx_mode_left = $urandom_range(20, 150);
    end
    tx_mode_left--;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  task automatic send_empty(input logic kind);
    send_request(make_req(kind, rbit(), 1'b1, rbyte(), rbit(), rbit(), rbit()));
  endtask

  task automatic send_pkt(input logic resp, input logic ok, input bit may_split);
    int n, cut;
    n   = pkt_bytes.size();
    cut = n;
    if (may_split && n > 1 && $urandom_range(0, 3) == 0) cut = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++)
      send_request(make_req(KIND_MAIN, resp, 1'b0, pkt_bytes[i], i == 0 || i == cut,
                            i == n - 1 || i == cut - 1, (i == n - 1) ? ok : rbit()));
    pkt_bytes.delete();
  endtask

  task automatic send_side_packet(input int n);
    logic resp;
    resp = rbit();
    if (n == 0) send_empty(KIND_SIDE);
    for (int i = 0; i < n; i++)
      send_request(make_req(KIND_SIDE, resp, 1'b0, rbyte(), i == 0, i == n - 1, rbit()));
  endtask

  task automatic send_reply_packet();
    if ($urandom_range(0, 3) == 0) begin
      pkt_bytes.push_back(rbyte());
    end else begin
      pkt_bytes.push_back(BYTE_SOH);
      repeat ($urandom_range(0, 10)) pkt_bytes.push_back(reply_char());
      if (rbit()) begin
        pkt_bytes.push_back(NUL);
        repeat ($urandom_range(0, 3)) pkt_bytes.push_back(rbyte());
      end
      if ($urandom_range(0, 99) == 0 && pkt_bytes.size() > 1)
        pkt_bytes[$urandom_range(1, pkt_bytes.size() - 1)] = rbyte();
    end
    send_pkt(1'b1, rbit(), 1'b0);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_request(make_req(rbit(), rbit(), $urandom_range(0, 7) == 0, rbyte(),
                            rbit(), rbit(), rbit()));
  endtask

  task automatic run_session();
    int r, v;
    logic resp, ok;
    logic [7:0] b;
    bit valid_port, side_open;
    resp       = 1'b0;
    ok         = ($urandom_range(0, 99) < 55);
    valid_port = 1'b1;
    v          = $urandom_range(1, 65535);
    r          = $urandom_range(0, 99);
    if (r < 58) begin
      push_text($sformatf("%0d", v));
    end else if (r < 66) begin
      v = 65535;
      push_text($sformatf("%0d", v));
    end else if (r < 72) begin
      v = 0;
      push_text($sformatf("%0d", v));
    end else if (r < 80) begin
      v = $urandom_range(0, 999);
      push_text($sformatf("%05d", v));
    end else begin
      valid_port = 1'b0;
      if (r < 85) begin
        push_text($sformatf("%0d", $urandom_range(65536, 99999)));
      end else if (r < 89) begin
        push_text($sformatf("%06d", $urandom_range(0, 999999)));
      end else if (r < 93) begin
        push_text($sformatf("%0d", v));
        b = rbyte();
        while (b >= DIGIT_0 && b <= DIGIT_9) b = rbyte();
        pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = b;
      end else if (r < 96) begin
        push_text($sformatf("%0d", v));
      end else begin
        push_text($sformatf("%0d", v));
        resp = 1'b1;
      end
    end
    if (r < 93 || r >= 96) pkt_bytes.push_back(NUL);
    send_pkt(resp, ok, 1'b0);
    side_open = valid_port && v != 0 && ok;

    if (side_open) begin
      if ($urandom_range(0, 19) == 0) begin
        pkt_bytes.push_back(NUL);
        send_pkt(1'b0, rbit(), 1'b0);
      end
      send_side_packet($urandom_range(0, 3));
      send_side_packet($urandom_range(0, 3));
    end

    repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom_range(NAME_LO, PRINT_HI)));
    pkt_bytes.push_back(NUL);
    repeat ($urandom_range(1, 8)) pkt_bytes.push_back(8'($urandom_range(NAME_LO, PRINT_HI)));
    pkt_bytes.push_back(NUL);
    repeat ($urandom_range(0, 12)) pkt_bytes.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
    pkt_bytes.push_back(NUL);
    if (rbit()) begin
      repeat ($urandom_range(0, 8)) pkt_bytes.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
      pkt_bytes.push_back(NUL);
    end
    if ($urandom_range(0, 24) == 0) pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = rbyte();
    send_pkt($urandom_range(0, 49) == 0, rbit(), 1'b1);

    while (sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_reply_packet();
      else if (r < 72) send_empty(KIND_MAIN);
      else if (r < 99) send_side_packet(rbit() ? 0 : $urandom_range(1, 3));
      else send_noise();
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_request(make_req(KIND_SIDE, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_request(make_req(KIND_SIDE, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
    send_request(make_req(KIND_SIDE, 1'b1, 1'b0, 8'hFF, 1'b0, 1'b1, 1'b1));
    send_request(make_req(KIND_MAIN, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b1, 1'b0));
    send_request(make_req(KIND_MAIN, 1'b0, 1'b0, DIGIT_9, 1'b1, 1'b0, 1'b1));
    send_request(make_req(KIND_MAIN, 1'b0, 1'b0, DIGIT_9, 1'b0, 1'b0, 1'b0));
    send_empty(KIND_MAIN);

    run_session();
    item_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d verdicts: %0d identified, %0d not compatible,",
             n_requests, n_found + n_notcompat + n_nomatch + n_inproc, n_found, n_notcompat);
    $display("%0d no match, %0d in process; %0d side channel opens, %0d long receiver holds.",
             n_nomatch, n_inproc, n_opens, long_holds);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : result_side
    int r, run;
    logic hold;
    @(posedge clk);
    forever begin
      if (long_holds < 2 && sent >= ((long_holds == 0) ? 400 : 1400)) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_holds++;
      end
      r    = $urandom_range(0, 99);
      hold = (r >= 45);
      if (r < 45) run = $urandom_range(1, 30);
      else if (r < 92) run = $urandom_range(1, 3);
      else run = $urandom_range(10, 40);
      result_stall <= hold;
      repeat (run) @(posedge clk);
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("Run stopped at its time limit with %0d verdicts outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
hdl/rsh_pkg.sv
hdl/rsh_front.sv
hdl/rsh_queue.sv
hdl/rsh_back.sv
hdl/rsh_session_recognizer.sv
tb/rsh_session_checker.sv
tb/tb_rsh_session_recognizer.sv
